// ===== sv/fbc_pkg.sv =====
// fbc_pkg: shared types and constants of the frustum box cull block
// depends on nothing; imported by fbc_ram users and frustum_box_cull
`default_nettype none

package fbc_pkg;

  // number of clip planes held in the plane table
  localparam int unsigned NUM_PLANES = 5;
  // address bits of the plane table (at least one)
  localparam int unsigned PLANE_AW   = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  // coefficient width, Q16.16
  localparam int unsigned COEF_W     = 32;
  // fractional bits of the Q16.16 format
  localparam int unsigned FRAC_W     = 16;
  // product width of two Q16.16 values
  localparam int unsigned PROD_W     = 2 * COEF_W;
  // accumulator width: three products and the shifted offset never overflow it
  localparam int unsigned SUM_W      = PROD_W + 2;

  // operation codes of an input beat
  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_TEST  = 1'b1
  } operation_e;

  // word selector of a plane write
  typedef enum logic [2:0] {
    WORD_A   = 3'd0,
    WORD_B   = 3'd1,
    WORD_C   = 3'd2,
    WORD_D   = 3'd3,
    WORD_SEL = 3'd4
  } plane_word_e;

  // control states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_TEST,
    ST_DRAIN
  } cull_state_e;

  // one row of the plane table
  typedef struct packed {
    logic [2:0]        sel;
    logic [COEF_W-1:0] coef_d;
    logic [COEF_W-1:0] coef_c;
    logic [COEF_W-1:0] coef_b;
    logic [COEF_W-1:0] coef_a;
  } plane_row_t;

  localparam int unsigned ROW_W = $bits(plane_row_t);

endpackage

`default_nettype wire

// ===== sv/fbc_ram.sv =====
// fbc_ram: generic single-write, single-read RAM with registered read data
// depends on nothing
`default_nettype none

module fbc_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 4,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/frustum_box_cull.sv =====
// frustum_box_cull: p-vertex visibility test of a box against stored clip planes
// depends on fbc_pkg and fbc_ram
//
// Usage: one input channel (in_valid_i/in_ready_o) carries either a plane
// write beat (operation 0: plane_slot, plane_word, word_value) or a test beat
// (operation 1: box low and high corners, Q16.16). Only test beats give a
// result beat on the output channel (out_valid_o/out_ready_i, visibility_o).
// The plane table is one row per plane (a, b, c, d, corner selects) in a RAM.
// A write reads the row, patches one word and writes it back; a write to a slot
// or word out of range is dropped. A test reads one plane per cycle into a
// shared evaluator (multiply stage, sum stage, sign check); the result is
// registered once the last plane has left the evaluator, and the next beat is
// taken after that.
// One item is in work at a time; the result sits in an output register, so
// the next beat is taken while the result still waits. A further test only
// stalls at its end if the earlier result has not been taken.
// Reset clears control state only; planes are undefined until written.
`default_nettype none

module frustum_box_cull
  import fbc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              operation_i,
  input  wire logic [2:0]        plane_slot_i,
  input  wire logic [2:0]        plane_word_i,
  input  wire logic signed [31:0] word_value_i,
  input  wire logic signed [31:0] lo_x_i,
  input  wire logic signed [31:0] lo_y_i,
  input  wire logic signed [31:0] lo_z_i,
  input  wire logic signed [31:0] hi_x_i,
  input  wire logic signed [31:0] hi_y_i,
  input  wire logic signed [31:0] hi_z_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   visibility_o
);

  cull_state_e state_q, state_d;

  logic                in_fire;
  logic                wr_ok;
  logic [PLANE_AW-1:0] plane_q, plane_d;
  logic                plane_last;

  // latched write beat
  logic [PLANE_AW-1:0] wr_slot_q;
  logic [2:0]          wr_word_q;
  logic [COEF_W-1:0]   wr_value_q;

  // latched box corners
  logic signed [COEF_W-1:0] lo_x_q, lo_y_q, lo_z_q, hi_x_q, hi_y_q, hi_z_q;

  // ram ports
  logic                ram_we, ram_re;
  logic [PLANE_AW-1:0] ram_raddr;
  plane_row_t          ram_rdata, ram_wdata;

  // evaluator pipeline
  logic                     s1_v_q, s2_v_q, s3_v_q;
  logic signed [COEF_W-1:0] corner_x, corner_y, corner_z;
  logic signed [PROD_W-1:0] prod_a_q, prod_b_q, prod_c_q;
  logic signed [PROD_W-1:0] prod_a_d, prod_b_d, prod_c_d;
  logic signed [SUM_W-1:0]  dterm_q, dterm_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic                     outside_q, outside_d;
  logic                     pipe_empty;

  logic out_valid_q, out_valid_d;
  logic vis_q;
  logic out_load;

  // handshake helpers
  assign in_fire    = in_valid_i && in_ready_o;
  assign wr_ok      = (32'(plane_slot_i) < NUM_PLANES) && (plane_word_i <= WORD_SEL);
  assign plane_last = (plane_q == PLANE_AW'(NUM_PLANES - 1));
  assign pipe_empty = !s1_v_q && !s2_v_q && !s3_v_q;
  assign out_load   = (state_q == ST_DRAIN) && pipe_empty && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (operation_i == OP_TEST) begin
            state_d = ST_TEST;
          end else if (wr_ok) begin
            state_d = ST_WRITE;
          end
        end
      end
      ST_WRITE: state_d = ST_IDLE;
      ST_TEST: begin
        if (plane_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o = 1'b0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    ram_raddr  = plane_q;
    plane_d    = plane_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        ram_raddr  = PLANE_AW'(plane_slot_i);
        ram_re     = in_fire && (operation_i == OP_WRITE) && wr_ok;
        plane_d    = '0;
      end
      ST_WRITE: ram_we = 1'b1;
      ST_TEST: begin
        ram_re  = 1'b1;
        plane_d = plane_last ? '0 : plane_q + PLANE_AW'(1);
      end
      ST_DRAIN: plane_d = '0;
      default: plane_d = '0;
    endcase
  end

  // patch one word of the row read back
  always_comb begin
    ram_wdata = ram_rdata;
    case (wr_word_q)
      WORD_A:   ram_wdata.coef_a = wr_value_q;
      WORD_B:   ram_wdata.coef_b = wr_value_q;
      WORD_C:   ram_wdata.coef_c = wr_value_q;
      WORD_D:   ram_wdata.coef_d = wr_value_q;
      WORD_SEL: ram_wdata.sel    = wr_value_q[2:0];
      default:  ram_wdata        = ram_rdata;
    endcase
  end

  fbc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_PLANES)
  ) u_plane_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_slot_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // corner choice and products
  always_comb begin
    corner_x = ram_rdata.sel[0] ? lo_x_q : hi_x_q;
    corner_y = ram_rdata.sel[1] ? lo_y_q : hi_y_q;
    corner_z = ram_rdata.sel[2] ? lo_z_q : hi_z_q;
    prod_a_d = $signed(ram_rdata.coef_a) * corner_x;
    prod_b_d = $signed(ram_rdata.coef_b) * corner_y;
    prod_c_d = $signed(ram_rdata.coef_c) * corner_z;
    dterm_d  = -(SUM_W'($signed(ram_rdata.coef_d)) <<< FRAC_W);
  end

  // plane sum and outside flag
  assign sum_d = SUM_W'(prod_a_q) + SUM_W'(prod_b_q) + SUM_W'(prod_c_q) + dterm_q;

  always_comb begin
    outside_d = outside_q;
    if (state_q == ST_IDLE) begin
      outside_d = 1'b0;
    end else if (s3_v_q && !sum_q[SUM_W-1] && (sum_q != '0)) begin
      outside_d = 1'b1;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign visibility_o = vis_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      plane_q     <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      outside_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      plane_q     <= plane_d;
      s1_v_q      <= (state_q == ST_TEST);
      s2_v_q      <= s1_v_q;
      s3_v_q      <= s2_v_q;
      outside_q   <= outside_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      wr_slot_q  <= PLANE_AW'(plane_slot_i);
      wr_word_q  <= plane_word_i;
      wr_value_q <= word_value_i;
      lo_x_q     <= lo_x_i;
      lo_y_q     <= lo_y_i;
      lo_z_q     <= lo_z_i;
      hi_x_q     <= hi_x_i;
      hi_y_q     <= hi_y_i;
      hi_z_q     <= hi_z_i;
    end
    prod_a_q <= prod_a_d;
    prod_b_q <= prod_b_d;
    prod_c_q <= prod_c_d;
    dterm_q  <= dterm_d;
    sum_q    <= sum_d;
    if (out_load) begin
      vis_q <= !outside_q;
    end
  end

`ifndef SYNTHESIS
  // a new beat is only taken with the evaluator empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> pipe_empty)
    else $error("beat taken while evaluator busy");

  // write-back never overlaps a plane read of a test
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !s1_v_q && !ram_re)
    else $error("row write-back overlaps a read");

  // plane counter stays within the table during a test
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TEST) |-> (32'(plane_q) < NUM_PLANES))
    else $error("plane counter out of range");

  // a result is loaded only after the last plane has left the evaluator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> $past(state_q) == ST_DRAIN || $past(state_q) == ST_TEST)
    else $error("result loaded before planes evaluated");
`endif

endmodule

`default_nettype wire
